/* design/hsm_pkg.sv */
package hsm_pkg;

    localparam int HSM_MAX_WIDTH  = 4096;
    localparam int HSM_MAX_HEIGHT = 4096;
    localparam int HSM_FIFO_DEPTH = 4;

    localparam int HEIGHT_W = 32;
    localparam int SLOPE_W  = 32;
    localparam int POS_W    = 12;
    localparam int GEOM_W   = 13;
    localparam int INV_W    = 24;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_CELL = 2'd2;

    // one slope job: two pairs of heights to difference plus the pixel tag
    typedef struct packed {
        logic [HEIGHT_W-1:0] hl;
        logic [HEIGHT_W-1:0] hr;
        logic [HEIGHT_W-1:0] hd;
        logic [HEIGHT_W-1:0] hu;
        logic [POS_W-1:0]    col;
        logic [POS_W-1:0]    row;
        logic                last;
    } hsm_job_t;

    typedef struct packed {
        logic [GEOM_W-1:0] width;
        logic [GEOM_W-1:0] height;
        logic              restart;
    } hsm_geom_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_BUILD,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_ACC,
        B_PREP,
        B_SQRT,
        B_DONE
    } back_state_t;

endpackage

/* design/heightmap_slope_magnitude.sv */
// Slope magnitude of a raster heightmap stream with clamped edges. Results trail the input
// by one row; the last row of a frame is flushed as it arrives, up to three results for one
// sample. The front reads four row-store words through one memory port and writes one
// (on row 0 it only writes), then hands on each job in turn. In the back end each result
// takes eight passes through the shared 33x29 multiplier (two gradient scalings, six
// partial squares) and a 32-step square root; the back end takes one job at a time and
// sets the sustained rate. A four-entry job queue sits between the two, and a result
// register lets the back end go on while m_ready is low.
// Writing image_width or image_height restarts the frame at pixel (0,0).
module heightmap_slope_magnitude
    import hsm_pkg::*;
#(
    parameter int MAX_WIDTH = HSM_MAX_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [HEIGHT_W-1:0]  s_height,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SLOPE_W-1:0]   m_slope,
    output logic [POS_W-1:0]     m_col,
    output logic [POS_W-1:0]     m_row,
    output logic                 m_frame_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [GEOM_W-1:0] width_reg, height_reg;
    logic [INV_W-1:0]  inv_reg;
    hsm_geom_t         geom;
    logic              cfg_wr;
    logic              q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    hsm_job_t          q_wr_data, q_rd_data;

    assign cfg_ready    = 1'b1;
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign geom.width   = width_reg;
    assign geom.height  = height_reg;
    assign geom.restart = cfg_wr &&
                          (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= GEOM_W'(4096);
            height_reg <= GEOM_W'(4096);
            inv_reg    <= INV_W'(8192);
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[GEOM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[GEOM_W-1:0];
                REG_INV_TWO_CELL: inv_reg    <= cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    hsm_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .geom      (geom),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_height  (s_height),
        .push_valid(q_wr_valid),
        .push_ready(q_wr_ready),
        .push_job  (q_wr_data)
    );

    hsm_fifo #(
        .DEPTH(HSM_FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(q_wr_valid),
        .wr_ready(q_wr_ready),
        .wr_data (q_wr_data),
        .rd_valid(q_rd_valid),
        .rd_ready(q_rd_ready),
        .rd_data (q_rd_data)
    );

    hsm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .inv_two_cell(inv_reg),
        .job_valid   (q_rd_valid),
        .job_ready   (q_rd_ready),
        .job         (q_rd_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_slope     (m_slope),
        .m_col       (m_col),
        .m_row       (m_row),
        .m_frame_last(m_frame_last)
    );

endmodule

/* design/hsm_fifo.sv */
module hsm_fifo
    import hsm_pkg::*;
#(
    parameter int DEPTH = HSM_FIFO_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  hsm_job_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output hsm_job_t rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    hsm_job_t          store [DEPTH];
    logic [PW-1:0]     wptr_reg;
    logic [PW-1:0]     rptr_reg;
    logic [PW:0]       count_reg;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (count_reg != (PW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            store[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd) begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/hsm_front.sv */
module hsm_front
    import hsm_pkg::*;
#(
    parameter int MAX_WIDTH = HSM_MAX_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  hsm_geom_t           geom,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [HEIGHT_W-1:0] s_height,
    output logic                push_valid,
    input  logic                push_ready,
    output hsm_job_t            push_job
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = CW + 1;

    front_state_t state_reg, state_next;

    logic [HEIGHT_W-1:0] mem [2**AW];
    logic [HEIGHT_W-1:0] rdata_reg;
    logic [AW-1:0]       rd_addr;

    logic [CW-1:0]       col_reg;
    logic [POS_W-1:0]    row_reg;
    logic                slot_reg;
    logic [HEIGHT_W-1:0] lw0_reg, lw1_reg, hin_reg;
    logic [HEIGHT_W-1:0] pl_reg, pr_reg, pc_reg, cc_reg;
    logic [2:0]          rd_cnt_reg;
    hsm_job_t            pend_reg [3];
    logic [1:0]          pn_reg, psel_reg;

    logic [CW:0]         weff;
    logic [GEOM_W-1:0]   heff;
    logic [CW-1:0]       cm1, cp1;
    logic                col_last, row_last;
    hsm_job_t            e0, e1, e2;
    logic [1:0]          n_jobs;

    always_comb begin
        if (geom.width < GEOM_W'(2)) begin
            weff = (CW+1)'(2);
        end else if (32'(geom.width) > MAX_WIDTH) begin
            weff = (CW+1)'(MAX_WIDTH);
        end else begin
            weff = (CW+1)'(geom.width);
        end
        if (geom.height < GEOM_W'(2)) begin
            heff = GEOM_W'(2);
        end else if (32'(geom.height) > HSM_MAX_HEIGHT) begin
            heff = GEOM_W'(HSM_MAX_HEIGHT);
        end else begin
            heff = geom.height;
        end
    end

    assign col_last = ({1'b0, col_reg} + 1'b1) >= weff;
    assign row_last = row_reg == POS_W'(heff - 1'b1);
    assign cm1      = (col_reg == '0) ? '0 : col_reg - 1'b1;
    assign cp1      = col_last ? CW'(weff - 1'b1) : col_reg + 1'b1;

    always_comb begin
        case (rd_cnt_reg)
            3'd0:    rd_addr = {~slot_reg, cm1};
            3'd1:    rd_addr = {~slot_reg, cp1};
            3'd2:    rd_addr = {~slot_reg, col_reg};
            default: rd_addr = {slot_reg, col_reg};
        endcase
    end

    // candidate jobs: pixel one row up, and on the last row the pixel to its left and the pixel itself
    always_comb begin
        e0.hl   = pl_reg;
        e0.hr   = pr_reg;
        e0.hd   = (row_reg == POS_W'(1)) ? pc_reg : cc_reg;
        e0.hu   = hin_reg;
        e0.col  = POS_W'(col_reg);
        e0.row  = row_reg - 1'b1;
        e0.last = 1'b0;

        e1.hl   = (col_reg == CW'(1)) ? lw0_reg : lw1_reg;
        e1.hr   = hin_reg;
        e1.hd   = pl_reg;
        e1.hu   = lw0_reg;
        e1.col  = POS_W'(cm1);
        e1.row  = row_reg;
        e1.last = 1'b0;

        e2.hl   = lw0_reg;
        e2.hr   = hin_reg;
        e2.hd   = pc_reg;
        e2.hu   = hin_reg;
        e2.col  = POS_W'(col_reg);
        e2.row  = row_reg;
        e2.last = 1'b1;

        if (row_reg == '0) begin
            n_jobs = 2'd0;
        end else if (!row_last) begin
            n_jobs = 2'd1;
        end else begin
            n_jobs = 2'd1 + 2'(col_reg != '0) + 2'(col_last);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    state_next = (row_reg == '0) ? F_BUILD : F_READ;
                end
            end
            F_READ: begin
                if (rd_cnt_reg == 3'd4) begin
                    state_next = F_BUILD;
                end
            end
            F_BUILD: begin
                state_next = (n_jobs == 2'd0) ? F_IDLE : F_PUSH;
            end
            F_PUSH: begin
                if (push_ready && psel_reg == pn_reg - 1'b1) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = state_reg == F_IDLE;
        push_valid = state_reg == F_PUSH;
        push_job   = pend_reg[psel_reg];
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
        if (state_reg == F_BUILD) begin
            mem[{slot_reg, col_reg}] <= hin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_valid) begin
            hin_reg <= s_height;
        end
        if (state_reg == F_READ) begin
            case (rd_cnt_reg)
                3'd1:    pl_reg <= rdata_reg;
                3'd2:    pr_reg <= rdata_reg;
                3'd3:    pc_reg <= rdata_reg;
                3'd4:    cc_reg <= rdata_reg;
                default: ;
            endcase
        end
        if (state_reg == F_BUILD) begin
            pend_reg[0] <= e0;
            pend_reg[1] <= (col_reg != '0) ? e1 : e2;
            pend_reg[2] <= e2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= 1'b0;
            lw0_reg    <= '0;
            lw1_reg    <= '0;
            rd_cnt_reg <= '0;
            pn_reg     <= '0;
            psel_reg   <= '0;
        end else if (geom.restart) begin
            state_reg  <= F_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= 1'b0;
            lw0_reg    <= '0;
            lw1_reg    <= '0;
            rd_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == F_READ) begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end else begin
                rd_cnt_reg <= '0;
            end
            if (state_reg == F_BUILD) begin
                pn_reg   <= n_jobs;
                psel_reg <= '0;
                if (col_last) begin
                    col_reg  <= '0;
                    slot_reg <= ~slot_reg;
                    row_reg  <= row_last ? '0 : row_reg + 1'b1;
                    lw0_reg  <= '0;
                    lw1_reg  <= '0;
                end else begin
                    col_reg <= col_reg + 1'b1;
                    lw1_reg <= lw0_reg;
                    lw0_reg <= hin_reg;
                end
            end
            if (state_reg == F_PUSH && push_ready) begin
                psel_reg <= psel_reg + 1'b1;
            end
        end
    end

endmodule

/* design/hsm_back.sv */
module hsm_back
    import hsm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [INV_W-1:0]   inv_two_cell,
    input  logic               job_valid,
    output logic               job_ready,
    input  hsm_job_t           job,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SLOPE_W-1:0] m_slope,
    output logic [POS_W-1:0]   m_col,
    output logic [POS_W-1:0]   m_row,
    output logic               m_frame_last
);

    back_state_t state_reg, state_next;

    logic [2:0]         idx_reg;
    logic [32:0]        adx_reg, ady_reg;
    logic [56:0]        gx_reg, gy_reg;
    logic [61:0]        prod_reg;
    logic [114:0]       acc_reg;
    logic [63:0]        n_reg;
    logic [34:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [4:0]         it_reg;
    logic               sat_reg;
    logic [POS_W-1:0]   col_reg, row_reg;
    logic               last_reg;
    logic               m_valid_reg;
    logic [SLOPE_W-1:0] m_slope_reg;
    logic [POS_W-1:0]   m_col_reg, m_row_reg;
    logic               m_last_reg;

    logic [32:0]        mul_a;
    logic [28:0]        mul_b;
    logic [114:0]       prod_ext;
    logic [34:0]        rem_t, trial;
    logic               out_free;

    function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {b[31], b} - {a[31], a};
        return d[32] ? (~d + 1'b1) : d;
    endfunction

    // shared multiplier: two gradient scalings, then squares as 29-bit partial products
    always_comb begin
        case (idx_reg)
            3'd0:    begin mul_a = adx_reg;               mul_b = 29'(inv_two_cell); end
            3'd1:    begin mul_a = ady_reg;               mul_b = 29'(inv_two_cell); end
            3'd2:    begin mul_a = 33'(gx_reg[28:0]);     mul_b = gx_reg[28:0];      end
            3'd3:    begin mul_a = 33'(gx_reg[56:29]);    mul_b = gx_reg[28:0];      end
            3'd4:    begin mul_a = 33'(gx_reg[56:29]);    mul_b = 29'(gx_reg[56:29]); end
            3'd5:    begin mul_a = 33'(gy_reg[28:0]);     mul_b = gy_reg[28:0];      end
            3'd6:    begin mul_a = 33'(gy_reg[56:29]);    mul_b = gy_reg[28:0];      end
            default: begin mul_a = 33'(gy_reg[56:29]);    mul_b = 29'(gy_reg[56:29]); end
        endcase
    end

    always_comb begin
        case (idx_reg)
            3'd3, 3'd6: prod_ext = 115'(prod_reg) << 30;
            3'd4, 3'd7: prod_ext = 115'(prod_reg) << 58;
            default:    prod_ext = 115'(prod_reg);
        endcase
    end

    assign rem_t    = {rem_reg[32:0], n_reg[63:62]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (job_valid) begin
                state_next = B_MUL;
            end
            B_MUL:  state_next = B_ACC;
            B_ACC:  state_next = (idx_reg == 3'd7) ? B_PREP : B_MUL;
            B_PREP: state_next = B_SQRT;
            B_SQRT: if (it_reg == 5'd31) begin
                state_next = B_DONE;
            end
            B_DONE: if (out_free) begin
                state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        job_ready    = state_reg == B_IDLE;
        m_valid      = m_valid_reg;
        m_slope      = m_slope_reg;
        m_col        = m_col_reg;
        m_row        = m_row_reg;
        m_frame_last = m_last_reg;
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                adx_reg  <= abs_diff(job.hl, job.hr);
                ady_reg  <= abs_diff(job.hd, job.hu);
                col_reg  <= job.col;
                row_reg  <= job.row;
                last_reg <= job.last;
                acc_reg  <= '0;
            end
            B_MUL: prod_reg <= mul_a * mul_b;
            B_ACC: begin
                case (idx_reg)
                    3'd0:    gx_reg <= prod_reg[56:0];
                    3'd1:    gy_reg <= prod_reg[56:0];
                    default: acc_reg <= acc_reg + prod_ext;
                endcase
            end
            B_PREP: begin
                sat_reg  <= |acc_reg[114:80];
                n_reg    <= acc_reg[79:16];
                rem_reg  <= '0;
                root_reg <= '0;
            end
            B_SQRT: begin
                n_reg <= {n_reg[61:0], 2'b00};
                if (rem_t >= trial) begin
                    rem_reg  <= rem_t - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            B_DONE: if (out_free) begin
                m_slope_reg <= sat_reg ? '1 : root_reg;
                m_col_reg   <= col_reg;
                m_row_reg   <= row_reg;
                m_last_reg  <= last_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            idx_reg     <= '0;
            it_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_IDLE) begin
                idx_reg <= '0;
            end else if (state_reg == B_ACC) begin
                idx_reg <= idx_reg + 1'b1;
            end
            it_reg <= (state_reg == B_SQRT) ? it_reg + 1'b1 : '0;
            if (state_reg == B_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* design/hsm_checker.sv */
module hsm_checker
    import hsm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [SLOPE_W-1:0]   m_slope,
    input logic [POS_W-1:0]     m_col,
    input logic [POS_W-1:0]     m_row,
    input logic                 m_frame_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slope) && $stable(m_col) &&
                                $stable(m_row) && $stable(m_frame_last))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // frame end is the bottom-right pixel, never on row 0 or column 0
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> m_row != '0 && m_col != '0)
        else $error("frame end flagged off the last row or column");

    // no result is valid too soon after reset
    a_no_early: assert property (@(posedge aclk)
        !aresetn |=> ##1 !m_valid)
        else $error("result too soon after reset");

endmodule

bind heightmap_slope_magnitude hsm_checker u_hsm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_slope     (m_slope),
    .m_col       (m_col),
    .m_row       (m_row),
    .m_frame_last(m_frame_last)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import hsm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic [SLOPE_W-1:0] slope;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic               last;
    } slope_result_t;

    typedef enum logic { STEP_REG, STEP_PIX } step_kind_t;

    typedef struct {
        step_kind_t          kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]         value;
        bit                  typed;
        logic [SLOPE_W-1:0]  typed_slope;
    } step_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [HEIGHT_W-1:0]  s_height;
    logic                 m_valid;
    logic                 m_ready;
    logic [SLOPE_W-1:0]   m_slope;
    logic [POS_W-1:0]     m_col;
    logic [POS_W-1:0]     m_row;
    logic                 m_frame_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    heightmap_slope_magnitude DUT (.*);

    // shadow state of the slope engine
    logic [HEIGHT_W-1:0] shadow_rows [2][HSM_MAX_WIDTH];
    logic [HEIGHT_W-1:0] recent [2];
    int unsigned         cur_col, cur_row, cur_slot;
    int unsigned         geom_w, geom_h;
    logic [INV_W-1:0]    scale;

    slope_result_t pending_slopes [$];
    int errors;
    int squeeze_req, squeeze_done;
    bit use_typed;
    logic [SLOPE_W-1:0] typed_val;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] root64(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [56:0] scaled_diff(logic [31:0] a, logic [31:0] b);
        logic signed [33:0] d;
        logic [33:0] m;
        logic [56:0] g;
        d = $signed({{2{b[31]}}, b}) - $signed({{2{a[31]}}, a});
        m = (d < 0) ? -d : d;
        g = m[32:0] * scale;
        return g;
    endfunction

    function automatic logic [31:0] slope_q16(logic [31:0] hl, logic [31:0] hr,
                                              logic [31:0] hd, logic [31:0] hu);
        logic [127:0] gx, gy, sum;
        gx = scaled_diff(hl, hr);
        gy = scaled_diff(hd, hu);
        sum = gx * gx + gy * gy;
        if (sum[127:80] != 0) return 32'hFFFF_FFFF;
        return root64(sum[79:16]);
    endfunction

    function automatic void push_slope(logic [31:0] s, int unsigned c, int unsigned r,
                                       logic last);
        slope_result_t e;
        e.slope = use_typed ? typed_val : s;
        e.col = c[POS_W-1:0];
        e.row = r[POS_W-1:0];
        e.last = last;
        pending_slopes.insert(pending_slopes.size(), e);
    endfunction

    function automatic void restart_raster();
        cur_col = 0;
        cur_row = 0;
        cur_slot = 0;
        recent[0] = 0;
        recent[1] = 0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        int unsigned g;
        g = v[GEOM_W-1:0];
        if (g < 2) g = 2;
        case (idx)
            REG_IMAGE_WIDTH: begin
                geom_w = (g > HSM_MAX_WIDTH) ? HSM_MAX_WIDTH : g;
                restart_raster();
            end
            REG_IMAGE_HEIGHT: begin
                geom_h = (g > HSM_MAX_HEIGHT) ? HSM_MAX_HEIGHT : g;
                restart_raster();
            end
            REG_INV_TWO_CELL: scale = v[INV_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_slopes(logic [31:0] hin);
        int unsigned c, r, cs, ps;
        logic [31:0] hl, hr, hd;
        c = (cur_col >= geom_w) ? geom_w - 1 : cur_col;
        r = (cur_row >= geom_h) ? geom_h - 1 : cur_row;
        cs = cur_slot;
        ps = cur_slot ^ 1;
        if (r >= 1) begin
            hl = shadow_rows[ps][(c == 0) ? 0 : c - 1];
            hr = shadow_rows[ps][(c + 1 >= geom_w) ? geom_w - 1 : c + 1];
            hd = (r == 1) ? shadow_rows[ps][c] : shadow_rows[cs][c];
            push_slope(slope_q16(hl, hr, hd, hin), c, r - 1, 1'b0);
        end
        shadow_rows[cs][c] = hin;
        if (r == geom_h - 1) begin
            if (c >= 1) begin
                hl = (c == 1) ? recent[0] : recent[1];
                push_slope(slope_q16(hl, hin, shadow_rows[ps][c - 1], recent[0]),
                           c - 1, r, 1'b0);
            end
            if (c == geom_w - 1)
                push_slope(slope_q16(recent[0], hin, shadow_rows[ps][c], hin), c, r, 1'b1);
        end
        recent[1] = recent[0];
        recent[0] = hin;
        if (c + 1 >= geom_w) begin
            cur_col = 0;
            cur_slot = cur_slot ^ 1;
            cur_row = (r + 1 >= geom_h) ? 0 : r + 1;
            recent[0] = 0;
            recent[1] = 0;
        end else begin
            cur_col = c + 1;
            cur_row = r;
        end
    endfunction

    // sender: bursts with random gaps
    int burst_left;

    task automatic send_height(logic [31:0] h);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_height <= h;
        do @(posedge aclk); while (!s_ready);
        predict_slopes(h);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge aclk);
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_slopes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_height(int mode);
        if (mode == 0) return $urandom;
        if (mode == 1) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return 32'h1000 + $urandom_range(0, 4095) - 2048;
    endfunction

    step_t plan [$];

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        step_t st;
        st = '{STEP_REG, idx, v, 1'b0, '0};
        plan.insert(plan.size(), st);
    endfunction

    function automatic void add_pix(logic [31:0] h, bit typed, logic [31:0] s);
        step_t st;
        st = '{STEP_PIX, '0, h, typed, s};
        plan.insert(plan.size(), st);
    endfunction

    initial begin
        int w, h, n, mode, total;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_height = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        squeeze_req = 0;
        burst_left = 0;
        use_typed = 1'b0;
        geom_w = HSM_MAX_WIDTH;
        geom_h = HSM_MAX_HEIGHT;
        scale = 24'd8192;
        restart_raster();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // full-scale swings with the largest scale saturate
        add_reg(REG_IMAGE_WIDTH, 2);
        add_reg(REG_IMAGE_HEIGHT, 2);
        add_reg(REG_INV_TWO_CELL, 32'hFFFFFF);
        add_pix(32'h7FFF_FFFF, 0, 0);
        add_pix(32'h8000_0000, 0, 0);
        add_pix(32'h8000_0000, 1, 32'hFFFF_FFFF);
        add_pix(32'h7FFF_FFFF, 1, 32'hFFFF_FFFF);
        // zero scale gives zero slope
        add_reg(REG_INV_TWO_CELL, 0);
        add_pix(5, 0, 0);
        add_pix(-3, 0, 0);
        add_pix(100, 1, 0);
        add_pix(32'h1234_5678, 1, 0);
        // out-of-range geometry clamps to the minimum; spare index is ignored
        add_reg(REG_SPARE, 32'hFFFF_FFFF);
        add_reg(REG_INV_TWO_CELL, 32'h10000);
        add_reg(REG_IMAGE_WIDTH, 0);
        add_reg(REG_IMAGE_HEIGHT, 0);
        add_pix(0, 0, 0);
        add_pix(32'h100, 0, 0);
        add_pix(32'h300, 0, 0);
        add_pix(32'h700, 0, 0);
        // 3x3 has a true interior pixel
        add_reg(REG_IMAGE_WIDTH, 3);
        add_reg(REG_IMAGE_HEIGHT, 3);
        add_reg(REG_INV_TWO_CELL, 32'h8000);
        for (int i = 0; i < 9; i++) add_pix(i * i * 32'h40 - 32'h200, 0, 0);

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_REG) begin
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                use_typed = plan[i].typed;
                typed_val = plan[i].typed_slope;
                send_height(plan[i].value);
                use_typed = 1'b0;
            end
        end

        total = 0;
        for (int f = 0; total < 80; f++) begin
            w = $urandom_range(2, 6);
            h = $urandom_range(2, 4);
            write_reg(REG_IMAGE_WIDTH, w);
            write_reg(REG_IMAGE_HEIGHT, h);
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE : REG_INV_TWO_CELL, $urandom);
            else
                write_reg(REG_INV_TWO_CELL, $urandom_range(0, 32'h30000));
            mode = $urandom_range(0, 2);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h - 1) : w * h;
            if (f == 2) squeeze_req++;
            for (int i = 0; i < n; i++) send_height(rand_height(mode));
            total += n;
        end

        // widest row, clamped geometry; a short stretch of row 0
        write_reg(REG_IMAGE_WIDTH, 32'h1FFF);
        write_reg(REG_IMAGE_HEIGHT, 32'h1FFF);
        write_reg(REG_INV_TWO_CELL, 32'h10000);
        for (int i = 0; i < 6; i++) send_height(rand_height(2));

        wait_idle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver: its own stall pattern, plus one long hold-off
    initial begin
        int hold, phase, pattern;
        m_ready = 1'b0;
        squeeze_done = 0;
        hold = 0;
        phase = 0;
        pattern = 0;
        forever begin
            @(negedge aclk);
            if (squeeze_req != squeeze_done) begin
                squeeze_done = squeeze_req;
                hold = 800;
            end
            if (phase == 0) begin
                phase = $urandom_range(20, 100);
                pattern = $urandom_range(0, 2);
            end
            phase--;
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                case (pattern)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(0, 1);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        slope_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_slopes.size() == 0) begin
                $error("unexpected result transaction col=%0d row=%0d", m_col, m_row);
                errors++;
            end else begin
                e = pending_slopes.pop_front();
                if (m_slope !== e.slope) begin
                    $error("slope: expected %h, got %h", e.slope, m_slope);
                    errors++;
                end
                if (m_col !== e.col) begin
                    $error("col: expected %0d, got %0d", e.col, m_col);
                    errors++;
                end
                if (m_row !== e.row) begin
                    $error("row: expected %0d, got %0d", e.row, m_row);
                    errors++;
                end
                if (m_frame_last !== e.last) begin
                    $error("frame_last: expected %b, got %b", e.last, m_frame_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
